// ===== rtl/kbr_pkg.sv =====
// ----------------------------------------------------------------------------
// kbr_pkg
// Shared types, key codes and the virtual-key to HID usage map for the boot
// keyboard report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package kbr_pkg;

	// slots carried in one boot report
	localparam int REPORT_SLOTS = 6;

	// modifier virtual-key codes
	localparam logic [7:0] VK_LCTRL   = 8'hA2;
	localparam logic [7:0] VK_SHIFT_L = 8'hA0;
	localparam logic [7:0] VK_LALT    = 8'hA4;
	localparam logic [7:0] VK_LWIN    = 8'h5B;
	localparam logic [7:0] VK_RCTRL   = 8'hA3;
	localparam logic [7:0] VK_SHIFT_R = 8'hA1;
	localparam logic [7:0] VK_RALT    = 8'hA5;
	localparam logic [7:0] VK_RWIN    = 8'h5C;

	// bases of the contiguous ranges of the usage map
	localparam logic [7:0] VK_A      = 8'h41;
	localparam logic [7:0] VK_Z      = 8'h5A;
	localparam logic [7:0] VK_0      = 8'h30;
	localparam logic [7:0] VK_1      = 8'h31;
	localparam logic [7:0] VK_9      = 8'h39;
	localparam logic [7:0] VK_NUM0   = 8'h60;
	localparam logic [7:0] VK_NUM1   = 8'h61;
	localparam logic [7:0] VK_NUM9   = 8'h69;
	localparam logic [7:0] VK_F1     = 8'h70;
	localparam logic [7:0] VK_F12    = 8'h7B;
	localparam logic [7:0] VK_F13    = 8'h7C;
	localparam logic [7:0] VK_F24    = 8'h87;

	localparam logic [7:0] USAGE_NONE = 8'h00;
	localparam logic [7:0] USAGE_A    = 8'h04;
	localparam logic [7:0] USAGE_0    = 8'h27;
	localparam logic [7:0] USAGE_1    = 8'h1E;
	localparam logic [7:0] USAGE_KP0  = 8'h62;
	localparam logic [7:0] USAGE_KP1  = 8'h59;
	localparam logic [7:0] USAGE_F1   = 8'h3A;
	localparam logic [7:0] USAGE_F13  = 8'h68;

	// one decoded key event
	typedef struct packed {
		logic       is_mod;
		logic [7:0] mod_mask;
		logic [7:0] usage;
		logic       key_up;
	} kbr_event_t;

	// one-hot modifier bit for a modifier code, zero for anything else
	function automatic logic [7:0] mod_mask_of(input logic [7:0] vk);
		logic [7:0] m;
		m = 8'h00;
		case (vk)
			VK_LCTRL:   m = 8'h01;
			VK_SHIFT_L: m = 8'h02;
			VK_LALT:    m = 8'h04;
			VK_LWIN:    m = 8'h08;
			VK_RCTRL:   m = 8'h10;
			VK_SHIFT_R: m = 8'h20;
			VK_RALT:    m = 8'h40;
			VK_RWIN:    m = 8'h80;
			default:    m = 8'h00;
		endcase
		return m;
	endfunction

	// virtual-key code to HID usage; unmapped codes give no usage
	function automatic logic [7:0] usage_of(input logic [7:0] vk);
		logic [7:0] u;
		u = USAGE_NONE;
		if (vk >= VK_A && vk <= VK_Z) begin
			u = USAGE_A + (vk - VK_A);
		end else if (vk == VK_0) begin
			u = USAGE_0;
		end else if (vk >= VK_1 && vk <= VK_9) begin
			u = USAGE_1 + (vk - VK_1);
		end else if (vk == VK_NUM0) begin
			u = USAGE_KP0;
		end else if (vk >= VK_NUM1 && vk <= VK_NUM9) begin
			u = USAGE_KP1 + (vk - VK_NUM1);
		end else if (vk >= VK_F1 && vk <= VK_F12) begin
			u = USAGE_F1 + (vk - VK_F1);
		end else if (vk >= VK_F13 && vk <= VK_F24) begin
			u = USAGE_F13 + (vk - VK_F13);
		end else begin
			case (vk)
				8'h03:   u = 8'h9B;
				8'h08:   u = 8'h2A;
				8'h09:   u = 8'h2B;
				8'h0D:   u = 8'h28;
				8'h13:   u = 8'h48;
				8'h14:   u = 8'h39;
				8'h1B:   u = 8'h29;
				8'h20:   u = 8'h2C;
				8'h21:   u = 8'h4B;
				8'h22:   u = 8'h4E;
				8'h23:   u = 8'h4D;
				8'h24:   u = 8'h4A;
				8'h25:   u = 8'h50;
				8'h26:   u = 8'h52;
				8'h27:   u = 8'h4F;
				8'h28:   u = 8'h51;
				8'h2C:   u = 8'h46;
				8'h2D:   u = 8'h49;
				8'h2E:   u = 8'h4C;
				8'h5B:   u = 8'hE3;
				8'h5C:   u = 8'hE7;
				8'h5D:   u = 8'h65;
				8'h6A:   u = 8'h55;
				8'h6B:   u = 8'h57;
				8'h6D:   u = 8'h56;
				8'h6E:   u = 8'h63;
				8'h6F:   u = 8'h54;
				8'h90:   u = 8'h53;
				8'h91:   u = 8'h47;
				8'hA0:   u = 8'hE1;
				8'hA1:   u = 8'hE5;
				8'hA2:   u = 8'hE0;
				8'hA3:   u = 8'hE4;
				8'hA4:   u = 8'hE2;
				8'hA5:   u = 8'hE6;
				8'hBA:   u = 8'h33;
				8'hBB:   u = 8'h2E;
				8'hBC:   u = 8'h36;
				8'hBD:   u = 8'h2D;
				8'hBE:   u = 8'h37;
				8'hBF:   u = 8'h38;
				8'hC0:   u = 8'h35;
				8'hDB:   u = 8'h2F;
				8'hDC:   u = 8'h31;
				8'hDD:   u = 8'h30;
				8'hDE:   u = 8'h34;
				8'hE2:   u = 8'h64;
				default: u = USAGE_NONE;
			endcase
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/kbr_if.sv =====
// ----------------------------------------------------------------------------
// kbr_event_if / kbr_report_if
// Valid/ready channels for key events in and boot reports out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbr_event_if;
	logic       valid;
	logic       ready;
	logic [7:0] virtual_key;
	logic       key_up;

	modport source (output valid, output virtual_key, output key_up, input ready);
	modport sink   (input valid, input virtual_key, input key_up, output ready);
endinterface

interface kbr_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifiers;
	logic [7:0] slot_zero;
	logic [7:0] slot_one;
	logic [7:0] slot_two;
	logic [7:0] slot_three;
	logic [7:0] slot_four;
	logic [7:0] slot_five;

	modport source (
		output valid, output modifiers,
		output slot_zero, output slot_one, output slot_two,
		output slot_three, output slot_four, output slot_five,
		input ready
	);
	modport sink (
		input valid, input modifiers,
		input slot_zero, input slot_one, input slot_two,
		input slot_three, input slot_four, input slot_five,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/keyboard_boot_report_builder_unit.sv =====
// ----------------------------------------------------------------------------
// keyboard_boot_report_builder_unit
// Builds a USB HID boot keyboard report from virtual-key press/release events.
// ----------------------------------------------------------------------------
// One report comes out for every key event taken in: the event is registered,
// then decoded, applied to the kept modifier byte and KEY_SLOTS key slots, and
// the resulting report is registered. A new event can be taken every cycle
// while the report register is empty or being drained; the slot search and
// table lookup sit in the single stage between the event register and the
// report register. While a report waits on the output, one more event is
// held in the event register before ready drops. Slots and modifiers are
// cleared by reset; reported slots past KEY_SLOTS read zero.
`default_nettype none

module keyboard_boot_report_builder_unit
	import kbr_pkg::*;
#(
	parameter int KEY_SLOTS = 6
)(
	input  logic          clk,
	input  logic          arst_n,
	kbr_event_if.sink     evt,
	kbr_report_if.source  rpt
);

	logic       valid_s1;
	logic [7:0] vk_s1;
	logic       up_s1;
	logic       adv;

	kbr_event_t ev;
	logic [7:0] mods_d;
	logic [7:0] slots_d  [KEY_SLOTS];
	logic [7:0] rep_slot [REPORT_SLOTS];

	logic       rpt_valid_q;
	logic [7:0] mods_q;
	logic [7:0] rep_q [REPORT_SLOTS];

	// stage moves when the report register is empty or being drained
	assign adv       = valid_s1 && (!rpt_valid_q || rpt.ready);
	assign evt.ready = !valid_s1 || adv;

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			vk_s1 <= evt.virtual_key;
			up_s1 <= evt.key_up;
		end
	end

	kbr_decode u_decode (
		.virtual_key (vk_s1),
		.key_up      (up_s1),
		.ev          (ev)
	);

	kbr_state #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (adv),
		.ev      (ev),
		.mods_d  (mods_d),
		.slots_d (slots_d)
	);

	// map kept slots onto the six report slots
	for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_rep
		if (g < KEY_SLOTS) begin : g_kept
			assign rep_slot[g] = slots_d[g];
		end else begin : g_absent
			assign rep_slot[g] = USAGE_NONE;
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (adv) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mods_q <= mods_d;
			for (int i = 0; i < REPORT_SLOTS; i++) begin
				rep_q[i] <= rep_slot[i];
			end
		end
	end

	assign rpt.valid      = rpt_valid_q;
	assign rpt.modifiers  = mods_q;
	assign rpt.slot_zero  = rep_q[0];
	assign rpt.slot_one   = rep_q[1];
	assign rpt.slot_two   = rep_q[2];
	assign rpt.slot_three = rep_q[3];
	assign rpt.slot_four  = rep_q[4];
	assign rpt.slot_five  = rep_q[5];

endmodule

`default_nettype wire

// ===== rtl/kbr_decode.sv =====
// ----------------------------------------------------------------------------
// kbr_decode
// Classifies a registered key event as modifier or key and looks up its
// HID usage.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_decode
	import kbr_pkg::*;
(
	input  logic [7:0] virtual_key,
	input  logic       key_up,
	output kbr_event_t ev
);

	logic [7:0] mask;

	// modifier bit wins over the usage path
	assign mask        = mod_mask_of(virtual_key);
	assign ev.is_mod   = |mask;
	assign ev.mod_mask = mask;
	assign ev.usage    = usage_of(virtual_key);
	assign ev.key_up   = key_up;

endmodule

`default_nettype wire

// ===== rtl/kbr_state.sv =====
// ----------------------------------------------------------------------------
// kbr_state
// Kept modifier byte and key slots, with the first-match slot search and
// the next-state values that go into the report.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_state
	import kbr_pkg::*;
#(
	parameter int KEY_SLOTS = 6
)(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd,
	input  kbr_event_t ev,
	output logic [7:0] mods_d,
	output logic [7:0] slots_d [KEY_SLOTS]
);

	logic [7:0] mods_q;
	logic [7:0] slots_q [KEY_SLOTS];
	logic [7:0] match;
	logic [7:0] put;
	logic       found;

	// modifier byte: set on press, clear on release
	always_comb begin
		mods_d = mods_q;
		if (upd && ev.is_mod) begin
			mods_d = ev.key_up ? (mods_q & ~ev.mod_mask) : (mods_q | ev.mod_mask);
		end
	end

	// press looks for an empty slot, release for the usage; first hit only
	assign match = ev.key_up ? ev.usage : USAGE_NONE;
	assign put   = ev.key_up ? USAGE_NONE : ev.usage;

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			slots_d[i] = slots_q[i];
		end
		if (upd && !ev.is_mod) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (!found && slots_q[i] == match) begin
					slots_d[i] = put;
					found      = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= 8'h00;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_q[i] <= USAGE_NONE;
			end
		end else begin
			mods_q <= mods_d;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_q[i] <= slots_d[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kbr_checker.sv =====
// ----------------------------------------------------------------------------
// kbr_checker
// Port-level checks on the boot report builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       evt_valid,
	input wire       evt_ready,
	input wire       rpt_valid,
	input wire       rpt_ready,
	input wire [7:0] rpt_modifiers,
	input wire [7:0] rpt_slot_zero,
	input wire [7:0] rpt_slot_five
);

	// a held report keeps its contents
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_modifiers)
			&& $stable(rpt_slot_zero) && $stable(rpt_slot_five))
		else $error("report changed while stalled");

	// a fresh report follows an event transfer through the event and report registers
	a_rpt_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(evt_valid && evt_ready, 2))
		else $error("report without an event");

	// events are refused only while a report is stalled
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> rpt_valid && !rpt_ready)
		else $error("event refused with output free");

endmodule

bind keyboard_boot_report_builder_unit kbr_checker u_kbr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt.valid),
	.evt_ready     (evt.ready),
	.rpt_valid     (rpt.valid),
	.rpt_ready     (rpt.ready),
	.rpt_modifiers (rpt.modifiers),
	.rpt_slot_zero (rpt.slot_zero),
	.rpt_slot_five (rpt.slot_five)
);

`default_nettype wire
